// ----- rtl/core/tbrl_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Token bucket rate limiter package
// Shared constants, command and status codes, and the types passed between
// the front stage, the request queue and the execution back end.
// ----------------------------------------------------------------------------
package tbrl_pkg;

    // Fixed-point format and tick field width
    localparam int FRACTION_BITS = 16;
    localparam int TICK_BITS     = 16;
    localparam int ELAPSED_W     = 16;
    localparam int TICK_W        = (TICK_BITS < ELAPSED_W) ? TICK_BITS : ELAPSED_W;

    // Datapath widths
    localparam int WORD_W = 32;
    localparam int PROD_W = TICK_W + WORD_W;
    localparam int SUM_W  = PROD_W + 1;

    // Serial divider
    localparam int DIV_STEPS = WORD_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Request queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Register reset values
    localparam logic [WORD_W-1:0] ONE_TOKEN      = WORD_W'(64'd1 << FRACTION_BITS);
    localparam logic [WORD_W-1:0] CAPACITY_RESET = WORD_W'(64'd10 << FRACTION_BITS);
    localparam logic [WORD_W-1:0] RATE_RESET     = ONE_TOKEN;
    localparam logic [WORD_W-1:0] INITIAL_RESET  = WORD_W'(64'd10 << FRACTION_BITS);
    localparam logic [WORD_W-1:0] LEVEL_RESET    =
        (INITIAL_RESET < CAPACITY_RESET) ? INITIAL_RESET : CAPACITY_RESET;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REFILL_RATE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_LEVEL = 2'd2;

    // Command codes on the input channel
    localparam logic [1:0] CMD_ADVANCE = 2'd0;
    localparam logic [1:0] CMD_ACQUIRE = 2'd1;
    localparam logic [1:0] CMD_RESTORE = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_WAIT  = 2'd1;
    localparam logic [1:0] ST_LATE  = 2'd2;
    localparam logic [1:0] ST_NEVER = 2'd3;

    // Decoded operation kind
    typedef enum logic [1:0] {
        OP_ADVANCE,
        OP_ACQUIRE,
        OP_RESTORE,
        OP_NONE
    } op_kind_t;

    // One classified request in the queue
    typedef struct packed {
        op_kind_t            kind;
        logic [TICK_W-1:0]   ticks;
        logic [WORD_W-1:0]   cost;
        logic [WORD_W-1:0]   wait_limit;
    } queue_entry_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // Configuration register file contents
    typedef struct packed {
        logic [WORD_W-1:0] capacity;
        logic [WORD_W-1:0] refill_rate;
        logic [WORD_W-1:0] initial_level;
    } cfg_t;

    // Back end sequencer states
    typedef enum logic [2:0] {
        B_IDLE,
        B_EXEC,
        B_ADD,
        B_DIV,
        B_ROUND,
        B_CMP,
        B_DONE
    } back_state_t;

endpackage : tbrl_pkg
`default_nettype wire

// ----- rtl/core/tbrl_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Token bucket front stage
// Accepts input requests, decodes the command and the used tick bits, and
// hands the classified request to the queue.
// ----------------------------------------------------------------------------
module tbrl_front
    import tbrl_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [1:0]            command,
    input  wire logic [ELAPSED_W-1:0]  elapsed_ticks,
    input  wire logic [WORD_W-1:0]     cost,
    input  wire logic [WORD_W-1:0]     wait_limit,
    input  wire queue_status_t         q_status,
    output logic                       q_push,
    output queue_entry_t               q_wdata
);

    logic         valid_reg;
    logic         valid_next;
    queue_entry_t entry_reg;
    queue_entry_t entry_next;
    logic         accept;
    op_kind_t     kind;

    // Decode the command
    always_comb
    begin
        case (command)
            CMD_ADVANCE: kind = OP_ADVANCE;
            CMD_ACQUIRE: kind = OP_ACQUIRE;
            CMD_RESTORE: kind = OP_RESTORE;
            default:     kind = OP_NONE;
        endcase
    end

    // Hold a request until the queue takes it
    assign q_push   = valid_reg && !q_status.full;
    assign in_stall = valid_reg && q_status.full;
    assign accept   = in_valid && !in_stall;
    assign q_wdata  = entry_reg;

    always_comb
    begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        if (accept)
        begin
            valid_next            = 1'b1;
            entry_next.kind       = kind;
            entry_next.ticks      = elapsed_ticks[TICK_W-1:0];
            entry_next.cost       = cost;
            entry_next.wait_limit = wait_limit;
        end
        else if (q_push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule : tbrl_front
`default_nettype wire

// ----- rtl/core/tbrl_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Token bucket request queue
// Short FIFO of classified requests between the front stage and the back end.
// ----------------------------------------------------------------------------
module tbrl_queue
    import tbrl_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire queue_entry_t  wdata,
    input  wire logic          pop,
    output queue_entry_t       rdata,
    output queue_status_t      status
);

    queue_entry_t         mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg;
    logic [QPTR_W-1:0]    wr_ptr_next;
    logic [QPTR_W-1:0]    rd_ptr_reg;
    logic [QPTR_W-1:0]    rd_ptr_next;
    logic [QCNT_W-1:0]    count_reg;
    logic [QCNT_W-1:0]    count_next;
    logic                 do_push;
    logic                 do_pop;

    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign rdata        = mem[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed request
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule : tbrl_queue
`default_nettype wire

// ----- rtl/core/tbrl_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Token bucket back end
// Owns the token level. Executes one queued request at a time: refill with a
// registered multiply, grant or refuse an acquire, compute the wait with a
// one-bit-per-cycle divider, and present the result in an output register.
// ----------------------------------------------------------------------------
module tbrl_back
    import tbrl_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cfg_t               cfg,
    input  wire queue_entry_t       q_rdata,
    input  wire queue_status_t      q_status,
    output logic                    q_pop,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    granted,
    output logic [1:0]              status,
    output logic [WORD_W-1:0]       wait_ticks,
    output logic [WORD_W-1:0]       tokens_available
);

    back_state_t          state_reg;
    back_state_t          state_next;
    queue_entry_t         op_reg;
    queue_entry_t         op_next;
    logic [WORD_W-1:0]    level_reg;
    logic [WORD_W-1:0]    level_next;
    logic [PROD_W-1:0]    prod_reg;
    logic [PROD_W-1:0]    prod_next;
    logic [WORD_W-1:0]    rem_reg;
    logic [WORD_W-1:0]    rem_next;
    logic [WORD_W-1:0]    quot_reg;
    logic [WORD_W-1:0]    quot_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 res_granted_reg;
    logic                 res_granted_next;
    logic [1:0]           res_status_reg;
    logic [1:0]           res_status_next;
    logic [WORD_W-1:0]    res_wait_reg;
    logic [WORD_W-1:0]    res_wait_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 out_granted_reg;
    logic                 out_granted_next;
    logic [1:0]           out_status_reg;
    logic [1:0]           out_status_next;
    logic [WORD_W-1:0]    out_wait_reg;
    logic [WORD_W-1:0]    out_wait_next;
    logic [WORD_W-1:0]    out_tokens_reg;
    logic [WORD_W-1:0]    out_tokens_next;

    logic [SUM_W-1:0]     sum;
    logic [WORD_W:0]      shifted;
    logic [WORD_W:0]      diff;
    logic [WORD_W-1:0]    restore_level;
    logic                 out_free;

    assign out_valid        = out_valid_reg;
    assign granted          = out_granted_reg;
    assign status           = out_status_reg;
    assign wait_ticks       = out_wait_reg;
    assign tokens_available = out_tokens_reg;

    assign out_free      = !out_valid_reg || !out_stall;
    assign q_pop         = (state_reg == B_IDLE) && !q_status.empty;
    assign sum           = SUM_W'(level_reg) + SUM_W'(prod_reg);
    assign shifted       = {rem_reg, quot_reg[WORD_W-1]};
    assign diff          = shifted - {1'b0, cfg.refill_rate};
    assign restore_level = (cfg.initial_level < cfg.capacity) ? cfg.initial_level
                                                               : cfg.capacity;

    // Sequence one request and compute its result
    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        level_next       = level_reg;
        prod_next        = prod_reg;
        rem_next         = rem_reg;
        quot_next        = quot_reg;
        count_next       = count_reg;
        res_granted_next = res_granted_reg;
        res_status_next  = res_status_reg;
        res_wait_next    = res_wait_reg;
        out_valid_next   = out_valid_reg;
        out_granted_next = out_granted_reg;
        out_status_next  = out_status_reg;
        out_wait_next    = out_wait_reg;
        out_tokens_next  = out_tokens_reg;

        // Drop the result once the receiver takes it
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            B_IDLE:
            begin
                if (!q_status.empty)
                begin
                    op_next    = q_rdata;
                    state_next = B_EXEC;
                end
            end

            B_EXEC:
            begin
                res_granted_next = 1'b0;
                res_status_next  = ST_OK;
                res_wait_next    = '0;
                case (op_reg.kind)
                    OP_ADVANCE:
                    begin
                        prod_next  = PROD_W'(op_reg.ticks) * PROD_W'(cfg.refill_rate);
                        state_next = B_ADD;
                    end
                    OP_ACQUIRE:
                    begin
                        if (level_reg >= op_reg.cost)
                        begin
                            level_next       = level_reg - op_reg.cost;
                            res_granted_next = 1'b1;
                            state_next       = B_DONE;
                        end
                        else if ((op_reg.cost > cfg.capacity) || (cfg.refill_rate == '0))
                        begin
                            res_status_next = ST_NEVER;
                            res_wait_next   = '1;
                            state_next      = B_DONE;
                        end
                        else
                        begin
                            quot_next  = op_reg.cost - level_reg;
                            rem_next   = '0;
                            count_next = '0;
                            state_next = B_DIV;
                        end
                    end
                    OP_RESTORE:
                    begin
                        level_next = restore_level;
                        state_next = B_DONE;
                    end
                    default:
                    begin
                        state_next = B_DONE;
                    end
                endcase
            end

            // Clamp the refilled level to capacity
            B_ADD:
            begin
                if (sum > SUM_W'(cfg.capacity))
                begin
                    level_next = cfg.capacity;
                end
                else
                begin
                    level_next = sum[WORD_W-1:0];
                end
                state_next = B_DONE;
            end

            // Restoring division, one quotient bit per cycle
            B_DIV:
            begin
                if (!diff[WORD_W])
                begin
                    rem_next  = diff[WORD_W-1:0];
                    quot_next = {quot_reg[WORD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = shifted[WORD_W-1:0];
                    quot_next = {quot_reg[WORD_W-2:0], 1'b0};
                end
                count_next = count_reg + 1'b1;
                if (count_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = B_ROUND;
                end
            end

            // Round the quotient up on a nonzero remainder
            B_ROUND:
            begin
                res_wait_next = quot_reg + WORD_W'(rem_reg != '0);
                state_next    = B_CMP;
            end

            B_CMP:
            begin
                res_status_next = (res_wait_reg <= op_reg.wait_limit) ? ST_WAIT : ST_LATE;
                state_next      = B_DONE;
            end

            // Load the output register when it is free
            B_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_granted_next = res_granted_reg;
                    out_status_next  = res_status_reg;
                    out_wait_next    = res_wait_reg;
                    out_tokens_next  = level_reg;
                    state_next       = B_IDLE;
                end
            end

            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            level_reg     <= LEVEL_RESET;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            level_reg     <= level_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        prod_reg        <= prod_next;
        rem_reg         <= rem_next;
        quot_reg        <= quot_next;
        res_granted_reg <= res_granted_next;
        res_status_reg  <= res_status_next;
        res_wait_reg    <= res_wait_next;
        out_granted_reg <= out_granted_next;
        out_status_reg  <= out_status_next;
        out_wait_reg    <= out_wait_next;
        out_tokens_reg  <= out_tokens_next;
    end

endmodule : tbrl_back
`default_nettype wire

// ----- rtl/core/token_bucket_rate_limiter.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Token bucket rate limiter
// Q16.16 token bucket with advance-time, acquire and restore requests.
//
// Input channel (in_valid/in_stall) carries command, elapsed_ticks, cost and
// wait_limit; a request is taken on a clock edge with in_valid high and
// in_stall low. Every request gives exactly one result on the output channel
// (out_valid/out_stall) with granted, status, wait_ticks, tokens_available.
// Registers capacity, refill_rate, initial_level are written through
// cfg_we/cfg_index/cfg_data; the user must write them only while no request
// is in flight, as the block itself does not enforce it.
// Path from the accepting edge to out_valid: front stage register, queue,
// back end execute state, add for advance or, for an acquire that must report
// a wait, the 32-step serial divider, round and compare; then done and the
// output register. The back end runs one request at a time, none new until
// its result is loaded; the front stage and 2-entry queue accept meanwhile.
// Reset: registers return to 10.0 capacity, 1.0 per tick, 10.0 initial,
// and the level to 10.0. A stalled result holds in the output register
// and the back end waits before loading the next one.
// ----------------------------------------------------------------------------
module token_bucket_rate_limiter
    import tbrl_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [WORD_W-1:0]     cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [1:0]            command,
    input  wire logic [ELAPSED_W-1:0]  elapsed_ticks,
    input  wire logic [WORD_W-1:0]     cost,
    input  wire logic [WORD_W-1:0]     wait_limit,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       granted,
    output logic [1:0]                 status,
    output logic [WORD_W-1:0]          wait_ticks,
    output logic [WORD_W-1:0]          tokens_available
);

    cfg_t          cfg_reg;
    cfg_t          cfg_next;
    queue_entry_t  q_wdata;
    queue_entry_t  q_rdata;
    queue_status_t q_status;
    logic          q_push;
    logic          q_pop;

    // Configuration register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_CAPACITY:      cfg_next.capacity      = cfg_data;
                REG_REFILL_RATE:   cfg_next.refill_rate   = cfg_data;
                REG_INITIAL_LEVEL: cfg_next.initial_level = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.capacity      <= CAPACITY_RESET;
            cfg_reg.refill_rate   <= RATE_RESET;
            cfg_reg.initial_level <= INITIAL_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tbrl_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .elapsed_ticks (elapsed_ticks),
        .cost          (cost),
        .wait_limit    (wait_limit),
        .q_status      (q_status),
        .q_push        (q_push),
        .q_wdata       (q_wdata)
    );

    tbrl_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wdata  (q_wdata),
        .pop    (q_pop),
        .rdata  (q_rdata),
        .status (q_status)
    );

    tbrl_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg_reg),
        .q_rdata          (q_rdata),
        .q_status         (q_status),
        .q_pop            (q_pop),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .granted          (granted),
        .status           (status),
        .wait_ticks       (wait_ticks),
        .tokens_available (tokens_available)
    );

endmodule : token_bucket_rate_limiter
`default_nettype wire
